[sv/ray_triangle_intersect_core_macros.svh]
// assertion helpers for the ray/triangle intersection core
`ifndef RAY_TRIANGLE_INTERSECT_CORE_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_CORE_MACROS_SVH

`ifndef SYNTH
`define RTI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rti check failed: implication");
`define RTI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rti check failed: next cycle");
`else
`define RTI_ASSERT_IMP(lbl, ante, cons)
`define RTI_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[sv/rti_pkg.sv]
package rti_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int DET_EPS_W       = 41;
    localparam int T_EPS_W         = 17;
    localparam int CFG_IDX_W       = 3;

    localparam logic [DET_EPS_W-1:0] DET_EPS_RST = 41'd2814749767;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5,
        REG_DET_EPS  = 3'd6,
        REG_T_EPS    = 3'd7
    } rti_reg_idx_t;

endpackage

[sv/ray_triangle_intersect_core.sv]
// throughput: one triangle item per cycle unless m_ready stalls the output, set by the
//   single-bit-per-stage division chain (COORD_WIDTH-1 stages) behind eight arithmetic
//   stages; no stage is reused
// reset: aresetn synchronous, active low; clears all stage valid bits and loads the ray
//   registers with origin 0, direction (0, 0, 1.0), det_epsilon 2814749767, t_epsilon 0
`include "ray_triangle_intersect_core_macros.svh"

module ray_triangle_intersect_core
    import rti_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_addr,
    input  logic [((COORD_WIDTH > DET_EPS_W) ? COORD_WIDTH : DET_EPS_W)-1:0] cfg_data,
    // triangle items in
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_a_x,
    input  logic signed [COORD_WIDTH-1:0] s_a_y,
    input  logic signed [COORD_WIDTH-1:0] s_a_z,
    input  logic signed [COORD_WIDTH-1:0] s_b_x,
    input  logic signed [COORD_WIDTH-1:0] s_b_y,
    input  logic signed [COORD_WIDTH-1:0] s_b_z,
    input  logic signed [COORD_WIDTH-1:0] s_c_x,
    input  logic signed [COORD_WIDTH-1:0] s_c_y,
    input  logic signed [COORD_WIDTH-1:0] s_c_z,
    // result items out
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic signed [COORD_WIDTH-1:0] m_distance
);

    localparam int CW    = COORD_WIDTH;
    localparam int FB    = FRAC_BITS;
    localparam int D     = CW + 1;          // edge / offset width
    localparam int HW    = 2 * CW + 2;      // h = dir x e2
    localparam int QW    = 2 * CW + 3;      // q = s x e1
    localparam int KL    = CW + 2;          // low slice of the wide multiplicand
    localparam int KH    = QW - KL;         // high slice, signed
    localparam int PLW   = D + KL + 1;
    localparam int PHW   = D + KH;
    localparam int W     = 3 * CW + 6;      // dot products
    localparam int NW    = W + CW + FB;     // shifted dividend
    localparam int DS    = CW - 1;          // one quotient bit per stage
    localparam int LAST  = CW + 7;
    localparam int NS    = CW + 8;
    localparam int TW    = CW + T_EPS_W;

    // ---------------------------------------------------------------
    // configuration registers (ray held across many triangles)
    // ---------------------------------------------------------------
    logic signed [CW-1:0]  org_reg [0:2];
    logic signed [CW-1:0]  dir_reg [0:2];
    logic [DET_EPS_W-1:0]  deps_reg;
    logic [T_EPS_W-1:0]    teps_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= CW'(1) << FB;
            deps_reg   <= DET_EPS_RST;
            teps_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (rti_reg_idx_t'(cfg_addr))
                REG_ORIGIN_X: org_reg[0] <= cfg_data[CW-1:0];
                REG_ORIGIN_Y: org_reg[1] <= cfg_data[CW-1:0];
                REG_ORIGIN_Z: org_reg[2] <= cfg_data[CW-1:0];
                REG_DIR_X:    dir_reg[0] <= cfg_data[CW-1:0];
                REG_DIR_Y:    dir_reg[1] <= cfg_data[CW-1:0];
                REG_DIR_Z:    dir_reg[2] <= cfg_data[CW-1:0];
                REG_DET_EPS:  deps_reg   <= cfg_data[DET_EPS_W-1:0];
                REG_T_EPS:    teps_reg   <= cfg_data[T_EPS_W-1:0];
            endcase
        end
    end

    // ---------------------------------------------------------------
    // valid bits and per-stage enables; a stage moves when it is empty
    // or the stage after it moves, so bubbles close up under a stall
    // ---------------------------------------------------------------
    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !v_reg[NS-1] || m_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign v_next  = {v_reg[NS-2:0], s_valid};
    assign s_ready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= (en & v_next) | (~en & v_reg);
        end
    end

    // ---------------------------------------------------------------
    // stage 0: edges e1 = b - a, e2 = c - a, offset s = origin - a
    // ---------------------------------------------------------------
    logic signed [D-1:0] e1_0_reg [0:2];
    logic signed [D-1:0] e2_0_reg [0:2];
    logic signed [D-1:0] s_0_reg  [0:2];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            e1_0_reg[0] <= D'(s_b_x) - D'(s_a_x);
            e1_0_reg[1] <= D'(s_b_y) - D'(s_a_y);
            e1_0_reg[2] <= D'(s_b_z) - D'(s_a_z);
            e2_0_reg[0] <= D'(s_c_x) - D'(s_a_x);
            e2_0_reg[1] <= D'(s_c_y) - D'(s_a_y);
            e2_0_reg[2] <= D'(s_c_z) - D'(s_a_z);
            s_0_reg[0]  <= D'(org_reg[0]) - D'(s_a_x);
            s_0_reg[1]  <= D'(org_reg[1]) - D'(s_a_y);
            s_0_reg[2]  <= D'(org_reg[2]) - D'(s_a_z);
        end
    end

    // ---------------------------------------------------------------
    // stage 1: the twelve cross-product terms
    // ---------------------------------------------------------------
    logic signed [2*CW:0]  hp_next [0:5];
    logic signed [2*D-1:0] qp_next [0:5];
    logic signed [2*CW:0]  hp_reg  [0:5];
    logic signed [2*D-1:0] qp_reg  [0:5];
    logic signed [D-1:0]   e1_1_reg [0:2];
    logic signed [D-1:0]   e2_1_reg [0:2];
    logic signed [D-1:0]   s_1_reg  [0:2];

    always_comb begin
        hp_next[0] = dir_reg[1] * e2_0_reg[2];
        hp_next[1] = dir_reg[2] * e2_0_reg[1];
        hp_next[2] = dir_reg[2] * e2_0_reg[0];
        hp_next[3] = dir_reg[0] * e2_0_reg[2];
        hp_next[4] = dir_reg[0] * e2_0_reg[1];
        hp_next[5] = dir_reg[1] * e2_0_reg[0];
        qp_next[0] = s_0_reg[1] * e1_0_reg[2];
        qp_next[1] = s_0_reg[2] * e1_0_reg[1];
        qp_next[2] = s_0_reg[2] * e1_0_reg[0];
        qp_next[3] = s_0_reg[0] * e1_0_reg[2];
        qp_next[4] = s_0_reg[0] * e1_0_reg[1];
        qp_next[5] = s_0_reg[1] * e1_0_reg[0];
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            hp_reg   <= hp_next;
            qp_reg   <= qp_next;
            e1_1_reg <= e1_0_reg;
            e2_1_reg <= e2_0_reg;
            s_1_reg  <= s_0_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: h = dir x e2, q = s x e1
    // ---------------------------------------------------------------
    logic signed [HW-1:0] h_reg [0:2];
    logic signed [QW-1:0] q_reg [0:2];
    logic signed [D-1:0]  e1_2_reg [0:2];
    logic signed [D-1:0]  e2_2_reg [0:2];
    logic signed [D-1:0]  s_2_reg  [0:2];

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            for (int c = 0; c < 3; c++) begin
                h_reg[c] <= HW'(hp_reg[2*c]) - HW'(hp_reg[2*c+1]);
                q_reg[c] <= QW'(qp_reg[2*c]) - QW'(qp_reg[2*c+1]);
            end
            e1_2_reg <= e1_1_reg;
            e2_2_reg <= e2_1_reg;
            s_2_reg  <= s_1_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: partial products of the four dot products
    // det = e1.h, u = s.h, v = dir.q, t = e2.q; the wide factor is
    // cut into an unsigned low slice and a signed high slice
    // ---------------------------------------------------------------
    logic signed [D-1:0]   opa [0:11];
    logic signed [QW-1:0]  opb [0:11];
    logic signed [PLW-1:0] pl_next [0:11];
    logic signed [PHW-1:0] ph_next [0:11];
    logic signed [PLW-1:0] pl_reg  [0:11];
    logic signed [PHW-1:0] ph_reg  [0:11];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            opa[c]     = e1_2_reg[c];
            opb[c]     = QW'(h_reg[c]);
            opa[3+c]   = s_2_reg[c];
            opb[3+c]   = QW'(h_reg[c]);
            opa[6+c]   = D'(dir_reg[c]);
            opb[6+c]   = q_reg[c];
            opa[9+c]   = e2_2_reg[c];
            opb[9+c]   = q_reg[c];
        end
        for (int m = 0; m < 12; m++) begin
            pl_next[m] = opa[m] * $signed({1'b0, opb[m][KL-1:0]});
            ph_next[m] = opa[m] * $signed(opb[m][QW-1:KL]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            pl_reg <= pl_next;
            ph_reg <= ph_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 4: recombine the slices
    // ---------------------------------------------------------------
    logic signed [W-1:0] prod_reg [0:11];

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            for (int m = 0; m < 12; m++) begin
                prod_reg[m] <= (W'(ph_reg[m]) <<< KL) + W'(pl_reg[m]);
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 5: sums; 0 det, 1 u numerator, 2 v numerator, 3 t numerator
    // ---------------------------------------------------------------
    logic signed [W-1:0] sum_reg [0:3];

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            for (int g = 0; g < 4; g++) begin
                sum_reg[g] <= prod_reg[3*g] + prod_reg[3*g+1] + prod_reg[3*g+2];
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 6: make det positive, numerators follow its sign
    // ---------------------------------------------------------------
    logic signed [W-1:0] det6_reg, un6_reg, vn6_reg, tn6_reg;

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            if (sum_reg[0][W-1]) begin
                det6_reg <= -sum_reg[0];
                un6_reg  <= -sum_reg[1];
                vn6_reg  <= -sum_reg[2];
                tn6_reg  <= -sum_reg[3];
            end else begin
                det6_reg <= sum_reg[0];
                un6_reg  <= sum_reg[1];
                vn6_reg  <= sum_reg[2];
                tn6_reg  <= sum_reg[3];
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 7: parallel, barycentric and behind-origin rejects, plus
    // saturation test t >= 2^(CW-1) done as a compare before dividing
    // ---------------------------------------------------------------
    logic signed [W:0]   uv_sum;
    logic [W-1:0]        det_u;
    logic [NW-1:0]       num_sh;
    logic                miss7_next, sat7_next;
    logic [NW-1:0]       r7_reg;
    logic [W-1:0]        d7_reg;
    logic                miss7_reg, sat7_reg;

    always_comb begin
        uv_sum     = (W+1)'(un6_reg) + (W+1)'(vn6_reg);
        det_u      = det6_reg;
        num_sh     = NW'(det_u) << (CW - 1);
        miss7_next = (det_u == '0)
                  || (det_u < W'(deps_reg))
                  || un6_reg[W-1]
                  || (un6_reg > det6_reg)
                  || vn6_reg[W-1]
                  || (uv_sum > (W+1)'(det6_reg))
                  || tn6_reg[W-1]
                  || (tn6_reg == '0);
        sat7_next  = (NW'(tn6_reg[W-2:0]) << FB) >= num_sh;
    end

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            r7_reg    <= NW'(tn6_reg[W-2:0]) << FB;
            d7_reg    <= det_u;
            miss7_reg <= miss7_next;
            sat7_reg  <= sat7_next;
        end
    end

    // ---------------------------------------------------------------
    // stages 8 .. CW+6: restoring division, one quotient bit per stage
    // ---------------------------------------------------------------
    logic [NW-1:0] dr_reg [0:DS-1];
    logic [CW-2:0] dq_reg [0:DS-1];
    logic [W-1:0]  dd_reg [0:DS-1];
    logic          dm_reg [0:DS-1];
    logic          ds_reg [0:DS-1];

    for (genvar j = 0; j < DS; j++) begin : g_div
        localparam int DBIT = CW - 2 - j;
        logic [NW-1:0] r_in;
        logic [NW-1:0] trial;
        logic [CW-2:0] q_in;
        logic [W-1:0]  d_in;
        logic          m_in, sa_in;

        if (j == 0) begin : g_first
            assign r_in  = r7_reg;
            assign q_in  = '0;
            assign d_in  = d7_reg;
            assign m_in  = miss7_reg;
            assign sa_in = sat7_reg;
        end else begin : g_rest
            assign r_in  = dr_reg[j-1];
            assign q_in  = dq_reg[j-1];
            assign d_in  = dd_reg[j-1];
            assign m_in  = dm_reg[j-1];
            assign sa_in = ds_reg[j-1];
        end

        assign trial = NW'(d_in) << DBIT;

        always_ff @(posedge aclk) begin
            if (en[8+j]) begin
                if (r_in >= trial) begin
                    dr_reg[j] <= r_in - trial;
                    dq_reg[j] <= q_in | ((CW-1)'(1) << DBIT);
                end else begin
                    dr_reg[j] <= r_in;
                    dq_reg[j] <= q_in;
                end
                dd_reg[j] <= d_in;
                dm_reg[j] <= m_in;
                ds_reg[j] <= sa_in;
            end
        end
    end

    // ---------------------------------------------------------------
    // output register: saturate, distance threshold, zero on a miss
    // ---------------------------------------------------------------
    logic [CW-1:0] t_val;
    logic          hit_next;
    logic          hit_reg;
    logic [CW-1:0] dist_reg;

    always_comb begin
        t_val    = ds_reg[DS-1] ? {1'b0, {(CW-1){1'b1}}} : {1'b0, dq_reg[DS-1]};
        hit_next = !dm_reg[DS-1] && (TW'(t_val) > TW'(teps_reg));
    end

    always_ff @(posedge aclk) begin
        if (en[LAST]) begin
            hit_reg  <= hit_next;
            dist_reg <= hit_next ? t_val : '0;
        end
    end

    assign m_valid    = v_reg[LAST];
    assign m_hit      = hit_reg;
    assign m_distance = dist_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `RTI_ASSERT_IMP(a_miss_gives_zero, m_valid && !m_hit, m_distance == '0)
    `RTI_ASSERT_IMP(a_hit_nonneg, m_valid && m_hit, !m_distance[CW-1])
    `RTI_ASSERT_NEXT(a_take_fills_first, s_valid && s_ready, v_reg[0])

endmodule
